FILE: rtl/rxp_pkg.sv
// ----------------------------------------------------------------------------
// rxp_pkg: shared types and constants of the rotate/project datapath
// Trig word type, register indexes and fixed constants of the sine table.
// ----------------------------------------------------------------------------
package rxp_pkg;

  localparam int unsigned TRIG_W  = 16;  // signed Q1.14 sine/cosine
  localparam int unsigned ANGLE_W = 16;  // 65536 = one turn
  localparam int unsigned VDIST_W = 10;
  localparam int unsigned CFG_W   = 16;

  localparam logic [VDIST_W-1:0] VDIST_RESET = 10'd200;

  // quarter-turn offset that turns a sine lookup into a cosine lookup
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  // Q30 constants of the Taylor evaluation
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned HORNER_DIV [6] = '{64'd156, 64'd110, 64'd72,
                                                 64'd42, 64'd20, 64'd6};

  typedef enum logic [1:0] {
    REG_ANGLE_X   = 2'd0,
    REG_ANGLE_Y   = 2'd1,
    REG_ANGLE_Z   = 2'd2,
    REG_VIEW_DIST = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
  } trig_t;

endpackage

FILE: rtl/rxp_front.sv
// ----------------------------------------------------------------------------
// rxp_front: input stage
// Accept a point, look up the six sines/cosines of the current angles and
// register both for the queue.
// ----------------------------------------------------------------------------
module rxp_front #(
  parameter int unsigned COORD_WIDTH        = 16,
  parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                full_i,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  input  logic [rxp_pkg::ANGLE_W-1:0]         angle_x_i,
  input  logic [rxp_pkg::ANGLE_W-1:0]         angle_y_i,
  input  logic [rxp_pkg::ANGLE_W-1:0]         angle_z_i,
  output logic                                valid_o,
  output logic signed [COORD_WIDTH-1:0]       x_o,
  output logic signed [COORD_WIDTH-1:0]       y_o,
  output logic signed [COORD_WIDTH-1:0]       z_o,
  output rxp_pkg::trig_t                      trig_o
);
  import rxp_pkg::*;

  // table size must be a multiple of four
  localparam int unsigned QTR  = SINE_TABLE_ENTRIES / 4;
  localparam int unsigned IDXW = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned RW   = $clog2(QTR + 1);

  // first-quadrant sine in Q1.14, entry rr of QTR+1
  function automatic logic [14:0] sine_q14(input int unsigned rr);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    t  = Q30_ONE;
    x  = (HALF_PI_Q30 * longint'(rr)) / QTR;
    x2 = (x * x) >> 30;
    for (int i = 0; i < 6; i++) begin
      t = Q30_ONE - (((x2 * t) >> 30) / HORNER_DIV[i]);
    end
    s = (x * t) >> 30;
    return 15'((s + (64'd1 << 15)) >> 16);
  endfunction

  logic [14:0] rom [QTR+1];
  for (genvar k = 0; k <= QTR; k++) begin : g_rom
    assign rom[k] = sine_q14(k);
  end

  logic [ANGLE_W-1:0]       ang  [6];
  logic signed [TRIG_W-1:0] look [6];

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_x_i + QUARTER_TURN;
  assign ang[2] = angle_y_i;
  assign ang[3] = angle_y_i + QUARTER_TURN;
  assign ang[4] = angle_z_i;
  assign ang[5] = angle_z_i + QUARTER_TURN;

  for (genvar a = 0; a < 6; a++) begin : g_look
    logic [31:0]     prod;
    logic [IDXW-1:0] idx;
    logic [IDXW-1:0] rel;
    logic [IDXW-1:0] rr;
    logic [1:0]      quad;
    logic [14:0]     mag;

    assign prod = 32'(ang[a]) * 32'(SINE_TABLE_ENTRIES);
    assign idx  = prod[IDXW+15:16];

    always_comb begin
      if (idx >= IDXW'(3 * QTR)) begin
        quad = 2'd3;
        rel  = idx - IDXW'(3 * QTR);
      end else if (idx >= IDXW'(2 * QTR)) begin
        quad = 2'd2;
        rel  = idx - IDXW'(2 * QTR);
      end else if (idx >= IDXW'(QTR)) begin
        quad = 2'd1;
        rel  = idx - IDXW'(QTR);
      end else begin
        quad = 2'd0;
        rel  = idx;
      end
      rr = quad[0] ? IDXW'(QTR) - rel : rel;
    end

    assign mag     = rom[rr[RW-1:0]];
    assign look[a] = quad[1] ? -TRIG_W'(mag) : TRIG_W'(mag);
  end

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i & ~full_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !full_i) begin
      x_o       <= point_x_i;
      y_o       <= point_y_i;
      z_o       <= point_z_i;
      trig_o.sx <= look[0];
      trig_o.cx <= look[1];
      trig_o.sy <= look[2];
      trig_o.cy <= look[3];
      trig_o.sz <= look[4];
      trig_o.cz <= look[5];
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: rtl/rxp_fifo.sv
// ----------------------------------------------------------------------------
// rxp_fifo: two-entry queue between front and back
// Hold front beats until the back takes them.
// ----------------------------------------------------------------------------
module rxp_fifo #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/rxp_div.sv
// ----------------------------------------------------------------------------
// rxp_div: pipelined restoring divider with signed saturation
// One quotient bit per stage; apply sign and clamp at the end.
// ----------------------------------------------------------------------------
module rxp_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned QW = 16
) (
  input  logic                 clk_i,
  input  logic [NW-1:0]        n_i,
  input  logic [NW-1:0]        d_i,
  input  logic                 neg_i,
  input  logic                 ovf_i,
  output logic signed [QW-1:0] q_o
);
  localparam int unsigned XW = NW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] d_q   [QW];
  logic [QW-1:0] quo_q [QW];
  logic          neg_q [QW];
  logic          ovf_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned K = QW - 1 - s;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] d_in;
    logic [QW-1:0] quo_in;
    logic          neg_in;
    logic          ovf_in;
    logic [XW-1:0] shifted;
    logic          take;

    if (s == 0) begin : g_head
      assign rem_in = n_i;
      assign d_in   = d_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
      assign ovf_in = ovf_i;
    end else begin : g_tail
      assign rem_in = rem_q[s-1];
      assign d_in   = d_q[s-1];
      assign quo_in = quo_q[s-1];
      assign neg_in = neg_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    assign shifted = XW'(d_in) << K;
    assign take    = XW'(rem_in) >= shifted;

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? NW'(XW'(rem_in) - shifted) : rem_in;
      d_q[s]   <= d_in;
      quo_q[s] <= quo_in | (QW'(take) << K);
      neg_q[s] <= neg_in;
      ovf_q[s] <= ovf_in;
    end
  end

  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAG = {1'b1, {(QW-1){1'b0}}};

  logic [QW-1:0] quo;
  assign quo = quo_q[QW-1];

  always_comb begin
    if (neg_q[QW-1]) begin
      q_o = (ovf_q[QW-1] || quo > NEG_MAG) ? $signed(NEG_MAG) : $signed(-quo);
    end else begin
      q_o = (ovf_q[QW-1] || quo > POS_MAX) ? $signed(POS_MAX) : $signed(quo);
    end
  end

endmodule

FILE: rtl/rxp_back.sv
// ----------------------------------------------------------------------------
// rxp_back: rotation and perspective pipeline
// Rotate about X, Y, Z, then divide by the distance term in two lanes.
// ----------------------------------------------------------------------------
module rxp_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [COORD_WIDTH-1:0]       x_i,
  input  logic signed [COORD_WIDTH-1:0]       y_i,
  input  logic signed [COORD_WIDTH-1:0]       z_i,
  input  rxp_pkg::trig_t                      trig_i,
  input  logic [rxp_pkg::VDIST_W-1:0]         view_distance_i,
  output logic                                valid_o,
  output logic signed [COORD_WIDTH-1:0]       screen_x_o,
  output logic signed [COORD_WIDTH-1:0]       screen_y_o,
  output logic                                behind_o
);
  import rxp_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned IW   = W + 2;
  localparam int unsigned PW   = IW + TRIG_W;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned NUMW = IW + 19;
  localparam int unsigned DW   = (IW > 18 ? IW : 18) + 2;
  localparam int unsigned NW   = (NUMW > DW ? NUMW : DW) + 2;

  // round half up from Q14 products
  function automatic logic signed [IW-1:0] rnd(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] w;
    w = v + SW'(8192);
    return IW'(w >>> 14);
  endfunction

  logic signed [18:0] dq;
  assign dq = $signed({1'b0, view_distance_i, 8'd0});

  logic                 v_q [8];
  logic signed [PW-1:0] m1_q [4];
  logic signed [PW-1:0] m3_q [4];
  logic signed [PW-1:0] m5_q [4];
  logic signed [W-1:0]  x1_q;
  logic signed [W-1:0]  x2c_q;
  trig_t                t1_q;
  trig_t                t2_q;
  trig_t                t3_q;
  trig_t                t4_q;
  logic signed [IW-1:0] y1_q;
  logic signed [IW-1:0] z1_q;
  logic signed [IW-1:0] y1c3_q;
  logic signed [IW-1:0] y1c4_q;
  logic signed [IW-1:0] x2_q;
  logic signed [IW-1:0] z2_q;
  logic signed [IW-1:0] x3_q;
  logic signed [IW-1:0] y3_q;
  logic signed [DW-1:0] den5_q;
  logic signed [DW-1:0] den6_q;
  logic signed [DW-1:0] den7_q;
  logic                 bh5_q;
  logic                 bh6_q;
  logic                 bh7_q;
  logic                 bh8_q;
  logic signed [NUMW-1:0] num_q [2];
  logic [NW-1:0]          npr_q [2];
  logic [NW-1:0]          dpr_q;
  logic                   neg_q [2];
  logic                   ovf_q [2];
  logic                   vd_q  [W];
  logic                   bd_q  [W];
  logic signed [W-1:0]    qx;
  logic signed [W-1:0]    qy;
  logic                   val_q;
  logic                   beh_q;
  logic signed [W-1:0]    sx_q;
  logic signed [W-1:0]    sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= 1'b0;
      end
      for (int i = 0; i < W; i++) begin
        vd_q[i] <= 1'b0;
      end
      val_q <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < 8; i++) begin
        v_q[i] <= v_q[i-1];
      end
      vd_q[0] <= v_q[7];
      for (int i = 1; i < W; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
      val_q <= vd_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    // rotate about X
    m1_q[0] <= PW'(y_i) * PW'(trig_i.cx);
    m1_q[1] <= PW'(z_i) * PW'(trig_i.sx);
    m1_q[2] <= PW'(y_i) * PW'(trig_i.sx);
    m1_q[3] <= PW'(z_i) * PW'(trig_i.cx);
    x1_q    <= x_i;
    t1_q    <= trig_i;

    y1_q  <= rnd(SW'(m1_q[0]) - SW'(m1_q[1]));
    z1_q  <= rnd(SW'(m1_q[2]) + SW'(m1_q[3]));
    x2c_q <= x1_q;
    t2_q  <= t1_q;

    // rotate about Y
    m3_q[0] <= PW'(x2c_q) * PW'(t2_q.cy);
    m3_q[1] <= PW'(z1_q) * PW'(t2_q.sy);
    m3_q[2] <= PW'(z1_q) * PW'(t2_q.cy);
    m3_q[3] <= PW'(x2c_q) * PW'(t2_q.sy);
    y1c3_q  <= y1_q;
    t3_q    <= t2_q;

    x2_q   <= rnd(SW'(m3_q[0]) + SW'(m3_q[1]));
    z2_q   <= rnd(SW'(m3_q[2]) - SW'(m3_q[3]));
    y1c4_q <= y1c3_q;
    t4_q   <= t3_q;

    // rotate about Z, form the distance term
    m5_q[0] <= PW'(x2_q) * PW'(t4_q.cz);
    m5_q[1] <= PW'(y1c4_q) * PW'(t4_q.sz);
    m5_q[2] <= PW'(x2_q) * PW'(t4_q.sz);
    m5_q[3] <= PW'(y1c4_q) * PW'(t4_q.cz);
    den5_q  <= DW'(dq) + DW'(z2_q);

    x3_q   <= rnd(SW'(m5_q[0]) - SW'(m5_q[1]));
    y3_q   <= rnd(SW'(m5_q[2]) + SW'(m5_q[3]));
    den6_q <= den5_q;
    bh6_q  <= bh5_q;

    num_q[0] <= NUMW'(x3_q) * NUMW'(dq);
    num_q[1] <= NUMW'(y3_q) * NUMW'(dq);
    den7_q   <= den6_q;
    bh7_q    <= bh6_q;

    // numerator 2|n| + d and divisor 2d give round half away from zero
    for (int l = 0; l < 2; l++) begin
      neg_q[l] <= num_q[l][NUMW-1];
      npr_q[l] <= (NW'($unsigned(num_q[l][NUMW-1] ? -num_q[l] : num_q[l])) << 1)
                  + NW'($unsigned(den7_q));
      ovf_q[l] <= (NW+W)'((NW'($unsigned(num_q[l][NUMW-1] ? -num_q[l] : num_q[l])) << 1)
                  + NW'($unsigned(den7_q))) >= ((NW+W)'($unsigned(den7_q)) << (W + 1));
    end
    dpr_q <= NW'($unsigned(den7_q)) << 1;
    bh8_q <= bh7_q;

    bd_q[0] <= bh8_q;
    for (int i = 1; i < W; i++) begin
      bd_q[i] <= bd_q[i-1];
    end

    beh_q <= vd_q[W-1] & bd_q[W-1];
    sx_q  <= bd_q[W-1] ? '0 : qx;
    sy_q  <= bd_q[W-1] ? '0 : qy;
  end

  assign bh5_q = (den5_q <= 0);

  rxp_div #(.NW(NW), .QW(W)) u_div_x (
    .clk_i (clk_i),
    .n_i   (npr_q[0]),
    .d_i   (dpr_q),
    .neg_i (neg_q[0]),
    .ovf_i (ovf_q[0]),
    .q_o   (qx)
  );

  rxp_div #(.NW(NW), .QW(W)) u_div_y (
    .clk_i (clk_i),
    .n_i   (npr_q[1]),
    .d_i   (dpr_q),
    .neg_i (neg_q[1]),
    .ovf_i (ovf_q[1]),
    .q_o   (qy)
  );

  assign valid_o    = val_q;
  assign behind_o   = beh_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

FILE: rtl/rotate_xyz_perspective_project.sv
// ----------------------------------------------------------------------------
// rotate_xyz_perspective_project: Euler XYZ rotation and perspective projection
// Rotate a Q8.8 point by three configured angles, then project it onto the
// screen plane at the configured view distance.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  point    | start_i & !busy_o       | point_x_i, point_y_i, point_z_i
//  result   | result_valid_o (strobe) | screen_x_o, screen_y_o,
//           |                         | behind_viewer_o
//  config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One beat per cycle sustained. The path runs through the front register,
// the queue, eight rotate/project stages, one stage per quotient bit in the
// divider lanes and the output register.
// Reset clears the angles to zero and the view distance to 200; no clearing
// pass is needed. The receiver cannot stall: the back never holds, so the
// queue drains every cycle and busy_o stays low in operation.
// The sine table size must be a multiple of four.
module rotate_xyz_perspective_project #(
  parameter int unsigned COORD_WIDTH        = 16,
  parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                          result_valid_o,
  output logic signed [COORD_WIDTH-1:0] screen_x_o,
  output logic signed [COORD_WIDTH-1:0] screen_y_o,
  output logic                          behind_viewer_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [rxp_pkg::CFG_W-1:0]     cfg_data_i
);
  import rxp_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned PLW = 3 * W + $bits(trig_t);

  // configuration registers
  logic [ANGLE_W-1:0] angle_x_q;
  logic [ANGLE_W-1:0] angle_y_q;
  logic [ANGLE_W-1:0] angle_z_q;
  logic [VDIST_W-1:0] view_distance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q       <= '0;
      angle_y_q       <= '0;
      angle_z_q       <= '0;
      view_distance_q <= VDIST_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ANGLE_X:   angle_x_q       <= cfg_data_i;
        REG_ANGLE_Y:   angle_y_q       <= cfg_data_i;
        REG_ANGLE_Z:   angle_z_q       <= cfg_data_i;
        REG_VIEW_DIST: view_distance_q <= cfg_data_i[VDIST_W-1:0];
      endcase
    end
  end

  // front: accept and look up trig
  logic                fr_valid;
  logic signed [W-1:0] fr_x;
  logic signed [W-1:0] fr_y;
  logic signed [W-1:0] fr_z;
  trig_t               fr_trig;
  logic                q_full;

  rxp_front #(
    .COORD_WIDTH        (COORD_WIDTH),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .full_i    (q_full),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .angle_x_i (angle_x_q),
    .angle_y_i (angle_y_q),
    .angle_z_i (angle_z_q),
    .valid_o   (fr_valid),
    .x_o       (fr_x),
    .y_o       (fr_y),
    .z_o       (fr_z),
    .trig_o    (fr_trig)
  );

  assign busy_o = q_full;

  // queue between front and back; the back takes a beat every cycle
  logic [PLW-1:0] q_wdata;
  logic [PLW-1:0] q_rdata;
  logic           q_valid;

  assign q_wdata = {fr_x, fr_y, fr_z, fr_trig};

  rxp_fifo #(.WIDTH(PLW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (q_wdata),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .full_o  (q_full)
  );

  // unpack the head beat
  logic signed [W-1:0] bk_x;
  logic signed [W-1:0] bk_y;
  logic signed [W-1:0] bk_z;
  trig_t               bk_trig;

  assign {bk_x, bk_y, bk_z, bk_trig} = q_rdata;

  // back: rotate and project
  rxp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (q_valid),
    .x_i             (bk_x),
    .y_i             (bk_y),
    .z_i             (bk_z),
    .trig_i          (bk_trig),
    .view_distance_i (view_distance_q),
    .valid_o         (result_valid_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .behind_o        (behind_viewer_o)
  );

endmodule

FILE: rtl/rxp_checker.sv
// ----------------------------------------------------------------------------
// rxp_checker: port-level checks of the rotate/project block
// Result timing against accepted beats and the behind-viewer encoding.
// ----------------------------------------------------------------------------
module rxp_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic signed [COORD_WIDTH-1:0] screen_x_o,
  input logic signed [COORD_WIDTH-1:0] screen_y_o,
  input logic                          behind_viewer_o
);
  localparam int unsigned LAT = COORD_WIDTH + 11;

  logic accept;
  assign accept = start_i & ~busy_o;

  // every result traces back to a beat accepted a fixed time earlier
  a_result_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, LAT))
    else $error("result without matching accepted beat");

  // behind the viewer forces zero screen coordinates
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && behind_viewer_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("behind viewer with nonzero screen output");

  // behind flag only rides on a result strobe
  a_behind_qualified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !behind_viewer_o)
    else $error("behind flag outside a result beat");

endmodule

bind rotate_xyz_perspective_project rxp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_checker (.*);

FILE: verif/tb_rotate_xyz_perspective_project.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotate_xyz_perspective_project: self-checking bench of the rotate/project
// Drive points through the start/busy command port under several angle and
// view-distance settings, predict each screen beat in fixed point and compare
// every strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rotate_xyz_perspective_project;
  import rxp_pkg::*;

  localparam int unsigned CW      = 16;
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned LATENCY = CW + 11;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 behind;
  } screen_t;

  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    bit                   typed;  // expected value given in the row
    screen_t              want;
  } point_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic signed [CW-1:0] point_x_i = '0;
  logic signed [CW-1:0] point_y_i = '0;
  logic signed [CW-1:0] point_z_i = '0;
  logic                 result_valid_o;
  logic signed [CW-1:0] screen_x_o;
  logic signed [CW-1:0] screen_y_o;
  logic                 behind_viewer_o;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  rotate_xyz_perspective_project #(
    .COORD_WIDTH        (CW),
    .SINE_TABLE_ENTRIES (ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .result_valid_o  (result_valid_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .behind_viewer_o (behind_viewer_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bench copy of the configuration registers
  logic [ANGLE_W-1:0] angle_q [3];
  logic [VDIST_W-1:0] view_dist_q;

  screen_t screen_queue [$];
  int      fail_count = 0;
  int      idle_pct = 0;

  // Build one sine table entry: fold into a quadrant, Taylor in Q30 Horner
  // steps, round half up to Q14.
  function automatic longint sine_word(int unsigned idx);
    longint unsigned u, quad, r, x, x2, t, s, q14;
    longint unsigned divs [6];
    divs = '{156, 110, 72, 42, 20, 6};
    u = longint'(idx % ENTRIES) * 4;
    quad = u / ENTRIES;
    r = u % ENTRIES;
    if (quad[0]) r = ENTRIES - r;
    x = (64'd1686629713 * r) / ENTRIES;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'd1 << 30) - (((x2 * t) >> 30) / divs[i]);
    s = (x * t) >> 30;
    q14 = (s + (64'd1 << 15)) >> 16;
    return (quad >= 2) ? -longint'(q14) : longint'(q14);
  endfunction

  function automatic longint sin_at(logic [ANGLE_W-1:0] a);
    return sine_word((int'(a) * ENTRIES) >> 16);
  endfunction

  function automatic longint cos_at(logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] b;
    b = a + 16'h4000;
    return sin_at(b);
  endfunction

  // Round a Q14-scaled sum to the nearest integer, ties toward plus infinity
  function automatic longint drop_q14(longint v);
    longint w;
    w = v + 8192;
    if (w >= 0) return w >>> 14;
    return -((-w + 16383) / 16384);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  function automatic screen_t project_point(logic signed [CW-1:0] px,
                                            logic signed [CW-1:0] py,
                                            logic signed [CW-1:0] pz);
    longint x, y, z, sx, cx, sy, cy, sz, cz, y1, z1, x2, z2, x3, y3, dq, den;
    longint num, mag, q;
    longint r3 [2];
    screen_t o;
    x = px; y = py; z = pz;
    sx = sin_at(angle_q[0]); cx = cos_at(angle_q[0]);
    sy = sin_at(angle_q[1]); cy = cos_at(angle_q[1]);
    sz = sin_at(angle_q[2]); cz = cos_at(angle_q[2]);
    y1 = drop_q14(y * cx - z * sx);
    z1 = drop_q14(y * sx + z * cx);
    x2 = drop_q14(x * cy + z1 * sy);
    z2 = drop_q14(z1 * cy - x * sy);
    x3 = drop_q14(x2 * cz - y1 * sz);
    y3 = drop_q14(x2 * sz + y1 * cz);
    dq = longint'(view_dist_q) * 256;
    den = dq + z2;
    o = '0;
    if (den <= 0) begin
      o.behind = 1'b1;
      return o;
    end
    r3[0] = x3; r3[1] = y3;
    for (int i = 0; i < 2; i++) begin
      num = r3[i] * dq;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) q = -q;
      if (i == 0) o.sx = clamp_coord(q);
      else o.sy = clamp_coord(q);
    end
    return o;
  endfunction

  // Check every strobed beat against the oldest prediction
  always @(posedge clk_i) begin
    screen_t want;
    if (rst_ni && result_valid_o) begin
      if (screen_queue.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d behind=%0b", $time,
                 screen_x_o, screen_y_o, behind_viewer_o);
        fail_count++;
      end else begin
        want = screen_queue.pop_front();
        if (screen_x_o !== want.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, want.sx, screen_x_o);
          fail_count++;
        end
        if (screen_y_o !== want.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, want.sy, screen_y_o);
          fail_count++;
        end
        if (behind_viewer_o !== want.behind) begin
          $display("%0t: behind expected %0b actual %0b", $time, want.behind,
                   behind_viewer_o);
          fail_count++;
        end
      end
    end
  end

  // Write one register at the falling edge; keep the bench copy in step
  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_VIEW_DIST) view_dist_q = value[VDIST_W-1:0];
    else angle_q[idx] = value[ANGLE_W-1:0];
  endtask

  // Hold the bus idle until every beat is back and the pipe is empty
  task automatic drain_pipe();
    while (screen_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Present one point; start stays high across back-to-back beats
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] pz, bit typed, screen_t want);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    screen_queue.push_back(typed ? want : project_point(px, py, pz));
    @(negedge clk_i);
  endtask

  task automatic random_angles();
    write_reg(REG_ANGLE_X, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_ANGLE_Y, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_ANGLE_Z, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_VIEW_DIST, ($urandom_range(3) == 0) ? 16'd1023 :
                             16'($urandom_range(1, 400)));
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'hFFFF));
      1: return $signed(16'($urandom_range(4096))) - 16'sd2048;
      2: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(512))) - 16'sd256;
    endcase
  endfunction

  initial begin
    point_row_t rows [$];
    screen_t    zero_s;
    zero_s = '0;
    angle_q = '{0, 0, 0};
    view_dist_q = VDIST_RESET;

    // Directed rows at reset settings (no rotation, d = 200): z = 0 gives
    // screen = point; the deepest negative z magnifies by 51200 / 18432.
    rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, zero_s});
    rows.push_back('{16'sh7FFF, 16'sh8000, 16'sd0, 1'b1,
                     screen_t'{16'sh7FFF, 16'sh8000, 1'b0}});
    rows.push_back('{16'sd256, -16'sd256, 16'sd0, 1'b1,
                     screen_t'{16'sd256, -16'sd256, 1'b0}});
    rows.push_back('{16'sd1000, 16'sd1000, 16'sh8000, 1'b1,
                     screen_t'{16'sd2778, 16'sd2778, 1'b0}});
    rows.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, zero_s});
    rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, zero_s});
    rows.push_back('{16'sh5555, 16'shAAAA, 16'sd100, 1'b0, zero_s});
    rows.push_back('{16'shAAAA, 16'sh5555, -16'sd100, 1'b0, zero_s});
    rows.push_back('{16'sd300, -16'sd77, -16'sd32767, 1'b0, zero_s});

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].typed,
                                 rows[i].want);
    start_i <= 1'b0;
    drain_pipe();

    // Extremes of the registers: largest angles and view distances 1 and 1023;
    // then d = 0 (out of range) and a quarter turn on each axis.
    write_reg(REG_ANGLE_X, 16'hFFFF);
    write_reg(REG_ANGLE_Y, 16'hFFFF);
    write_reg(REG_ANGLE_Z, 16'hFFFF);
    write_reg(REG_VIEW_DIST, 16'd1);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 0, zero_s);
    start_i <= 1'b0;
    drain_pipe();
    write_reg(REG_ANGLE_X, QUARTER_TURN);
    write_reg(REG_ANGLE_Y, QUARTER_TURN);
    write_reg(REG_ANGLE_Z, QUARTER_TURN);
    write_reg(REG_VIEW_DIST, 16'hFC00);  // bits above the width drop: d = 0
    send_point(16'sd500, 16'sd500, 16'sd500, 0, zero_s);
    send_point(16'sd500, 16'sd500, -16'sd500, 0, zero_s);
    start_i <= 1'b0;
    drain_pipe();
    write_reg(REG_VIEW_DIST, 16'd1023);
    send_point(16'sh7FFF, -16'sd1, 16'sh8000, 0, zero_s);
    send_point(16'sh8000, 16'sd1, 16'sh7FFF, 0, zero_s);
    start_i <= 1'b0;
    drain_pipe();

    // Random phases: fresh settings each phase, idling varies by phase
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 86;
        2: idle_pct = 22;
        default: idle_pct = 50;
      endcase
      random_angles();
      for (int i = 0; i < 54; i++) send_point(rand_coord(), rand_coord(), rand_coord(), 0,
                                             zero_s);
      start_i <= 1'b0;
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
